### hw/rtl/vmt_pkg.sv
// vmt_pkg: shared types and constants for the vertex matrix transform
// no dependencies; used by vmt_lane, vmt_merge and vertex_matrix_transform
`default_nettype none

package vmt_pkg;

   localparam int WORD_W = 32;
   localparam int VEC_N  = 4;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_XFORM = 1'b1;

   // saturation limits of one result component
   localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [VEC_N-1:0][WORD_W-1:0] vec4_type;

   // per-stage load enables shared by all lanes
   typedef struct packed {
      logic en_mul;
      logic en_add;
      logic en_sat;
   } lane_ctl_type;

   // one finished result
   typedef struct packed {
      logic [WORD_W-1:0] out_x;
      logic [WORD_W-1:0] out_y;
      logic [WORD_W-1:0] out_z;
      logic [WORD_W-1:0] out_w;
      logic              clipped;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/vertex_matrix_transform.sv
// vertex_matrix_transform: 4x4 column-major fixed-point matrix times vertex
// depends on vmt_pkg, vmt_lane and vmt_merge
//
// Usage:
//   Requests arrive on req_valid/req_ready. A request with req_op = load writes
//   req_element_value into matrix element req_element_index (column-major) and
//   yields no response. A transform request multiplies the stored matrix by
//   (req_vx, req_vy, req_vz, req_vw) and yields one response on rsp_valid/
//   rsp_ready with the four saturated components and rsp_clipped.
//   A transform sees every load accepted before it.
// Pipeline: the product register loads at the accepting edge, then the
//   pair-sum, saturate and output registers follow in that order.
// Throughput: one request per cycle while req_ready is high, loads and transforms
//   mixed freely; four row lanes of four 32x32 multipliers each work every cycle.
// Reset: the matrix returns to identity (diagonal 1 << FRAC_BITS) and the
//   pipeline empties.
// Stall: the output stage has a two-entry buffer; while rsp_ready is low the
//   pipeline keeps filling and req_ready drops once all stages hold requests.
`default_nettype none

module vertex_matrix_transform #(
   parameter int FRAC_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_op,
   input  wire  [3:0]                   req_element_index,
   input  wire  signed [31:0]           req_element_value,
   input  wire  signed [31:0]           req_vx,
   input  wire  signed [31:0]           req_vy,
   input  wire  signed [31:0]           req_vz,
   input  wire  signed [31:0]           req_vw,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [31:0]           rsp_out_x,
   output logic signed [31:0]           rsp_out_y,
   output logic signed [31:0]           rsp_out_z,
   output logic signed [31:0]           rsp_out_w,
   output logic                         rsp_clipped
);

   localparam int N_ELEM = vmt_pkg::VEC_N * vmt_pkg::VEC_N;
   localparam vmt_pkg::word_type ONE_FIX = vmt_pkg::word_type'(1) << FRAC_BITS;

   vmt_pkg::word_type    matrix_ff [N_ELEM];
   vmt_pkg::vec4_type    row_m [vmt_pkg::VEC_N];
   vmt_pkg::vec4_type    vin;
   vmt_pkg::lane_ctl_type ctl;
   vmt_pkg::result_type  out_data;
   logic [vmt_pkg::VEC_N-1:0][vmt_pkg::WORD_W-1:0] lane_value;
   logic [vmt_pkg::VEC_N-1:0] lane_clip;
   logic mul_v_ff, mul_v_in, add_v_ff, add_v_in, sat_v_ff, sat_v_in;
   logic rdy_mul, rdy_add, rdy_sat, rdy_out;
   logic accept, do_load;

   assign accept  = req_valid && req_ready;
   assign do_load = accept && (req_op == vmt_pkg::OP_LOAD);

   // matrix store, identity at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vmt_pkg::VEC_N; r++) begin
            for (int c = 0; c < vmt_pkg::VEC_N; c++) begin
               matrix_ff[c * vmt_pkg::VEC_N + r] <= (r == c) ? ONE_FIX : '0;
            end
         end
      end else if (do_load) begin
         matrix_ff[req_element_index] <= req_element_value;
      end
   end

   // row r of the matrix feeds lane r
   always_comb begin
      for (int r = 0; r < vmt_pkg::VEC_N; r++) begin
         for (int c = 0; c < vmt_pkg::VEC_N; c++) begin
            row_m[r][c] = matrix_ff[c * vmt_pkg::VEC_N + r];
         end
      end
      vin[0] = req_vx;
      vin[1] = req_vy;
      vin[2] = req_vz;
      vin[3] = req_vw;
   end

   // stage advance control
   always_comb begin
      rdy_sat    = !sat_v_ff || rdy_out;
      rdy_add    = !add_v_ff || rdy_sat;
      rdy_mul    = !mul_v_ff || rdy_add;
      req_ready  = rdy_mul;
      ctl.en_mul = rdy_mul;
      ctl.en_add = rdy_add;
      ctl.en_sat = rdy_sat;
      mul_v_in   = rdy_mul ? (req_valid && (req_op == vmt_pkg::OP_XFORM)) : mul_v_ff;
      add_v_in   = rdy_add ? mul_v_ff : add_v_ff;
      sat_v_in   = rdy_sat ? add_v_ff : sat_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         add_v_ff <= 1'b0;
         sat_v_ff <= 1'b0;
      end else begin
         mul_v_ff <= mul_v_in;
         add_v_ff <= add_v_in;
         sat_v_ff <= sat_v_in;
      end
   end

   // one lane per output row
   for (genvar r = 0; r < vmt_pkg::VEC_N; r++) begin : g_lane
      vmt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock     (clock),
         .ctl       (ctl),
         .row_m     (row_m[r]),
         .vin       (vin),
         .res_value (lane_value[r]),
         .res_clip  (lane_clip[r])
      );
   end

   // merge lanes into the response buffer
   vmt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sat_v_ff),
      .in_ready   (rdy_out),
      .lane_value (lane_value),
      .lane_clip  (lane_clip),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_out_x   = out_data.out_x;
   assign rsp_out_y   = out_data.out_y;
   assign rsp_out_z   = out_data.out_z;
   assign rsp_out_w   = out_data.out_w;
   assign rsp_clipped = out_data.clipped;

   // a load request never enters the arithmetic pipeline
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      do_load |=> !mul_v_ff)
      else $error("load request entered the pipeline");

   // a transform request always occupies the product stage next cycle
   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == vmt_pkg::OP_XFORM) |=> mul_v_ff)
      else $error("transform request lost");

   // a load lands in the addressed matrix element
   a_load_written: assert property (@(posedge clock) disable iff (reset)
      do_load |=> (matrix_ff[$past(req_element_index)] == $past(req_element_value)))
      else $error("matrix element not written");

endmodule

`default_nettype wire

### hw/rtl/vmt_lane.sv
// vmt_lane: one output row of the transform (multiply, pair add, sum/shift/saturate)
// depends on vmt_pkg; instanced four times by vertex_matrix_transform
`default_nettype none

module vmt_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire                              clock,
   input  vmt_pkg::lane_ctl_type            ctl,
   input  vmt_pkg::vec4_type                row_m,
   input  vmt_pkg::vec4_type                vin,
   output logic [vmt_pkg::WORD_W-1:0]       res_value,
   output logic                             res_clip
);

   localparam int PROD_W = 2 * vmt_pkg::WORD_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(vmt_pkg::SAT_MAX);
   localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(vmt_pkg::SAT_MIN);

   logic signed [PROD_W-1:0] prod_ff [vmt_pkg::VEC_N];
   logic signed [PROD_W-1:0] prod_in [vmt_pkg::VEC_N];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  shifted;
   logic [vmt_pkg::WORD_W-1:0] value_ff, value_in;
   logic                       clip_ff, clip_in;

   // full signed products of matrix row and vertex
   always_comb begin
      for (int c = 0; c < vmt_pkg::VEC_N; c++) begin
         prod_in[c] = $signed(row_m[c]) * $signed(vin[c]);
      end
   end

   // pairwise sums, exact
   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   end

   // final sum, floor shift and saturation
   always_comb begin
      sum     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
      shifted = sum >>> FRAC_BITS;
      if (shifted > SUM_HI) begin
         value_in = vmt_pkg::SAT_MAX;
         clip_in  = 1'b1;
      end else if (shifted < SUM_LO) begin
         value_in = vmt_pkg::SAT_MIN;
         clip_in  = 1'b1;
      end else begin
         value_in = shifted[vmt_pkg::WORD_W-1:0];
         clip_in  = 1'b0;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.en_mul) begin
         for (int c = 0; c < vmt_pkg::VEC_N; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
      if (ctl.en_add) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
      if (ctl.en_sat) begin
         value_ff <= value_in;
         clip_ff  <= clip_in;
      end
   end

   assign res_value = value_ff;
   assign res_clip  = clip_ff;

endmodule

`default_nettype wire

### hw/rtl/vmt_merge.sv
// vmt_merge: combines the four lane results and holds them in a two-entry output buffer
// depends on vmt_pkg; instanced by vertex_matrix_transform
`default_nettype none

module vmt_merge (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         in_valid,
   output logic                                        in_ready,
   input  wire  [vmt_pkg::VEC_N-1:0][vmt_pkg::WORD_W-1:0] lane_value,
   input  wire  [vmt_pkg::VEC_N-1:0]                   lane_clip,
   output logic                                        out_valid,
   input  wire                                         out_ready,
   output vmt_pkg::result_type                         out_data
);

   vmt_pkg::result_type merged;
   vmt_pkg::result_type main_ff, main_in, skid_ff, skid_in;
   logic                main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   logic                push, pop;

   // gather lanes, any saturated lane flags the result
   always_comb begin
      merged.out_x   = lane_value[0];
      merged.out_y   = lane_value[1];
      merged.out_z   = lane_value[2];
      merged.out_w   = lane_value[3];
      merged.clipped = |lane_clip;
   end

   assign in_ready = !skid_v_ff;
   assign push     = in_valid && in_ready;
   assign pop      = main_v_ff && out_ready;

   // output register with skid entry
   always_comb begin
      main_in   = main_ff;
      skid_in   = skid_ff;
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      if (pop || !main_v_ff) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            main_in   = merged;
            main_v_in = push;
         end
      end else if (push) begin
         skid_in   = merged;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   // skid entry only fills behind a held output
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry valid without output entry");

   // a clipped result carries at least one saturated component
   a_clip_means_limit: assert property (@(posedge clock) disable iff (reset)
      (main_v_ff && main_ff.clipped) |->
         (main_ff.out_x == vmt_pkg::SAT_MAX || main_ff.out_x == vmt_pkg::SAT_MIN ||
          main_ff.out_y == vmt_pkg::SAT_MAX || main_ff.out_y == vmt_pkg::SAT_MIN ||
          main_ff.out_z == vmt_pkg::SAT_MAX || main_ff.out_z == vmt_pkg::SAT_MIN ||
          main_ff.out_w == vmt_pkg::SAT_MAX || main_ff.out_w == vmt_pkg::SAT_MIN))
      else $error("clipped result without saturated component");

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench: self-checking bench for the 4x4 fixed-point vertex transform
// depends on vmt_pkg and vertex_matrix_transform; a directed table runs first,
// then random loads and transforms are checked against an in-bench predictor

module testbench;

   localparam int FRAC = 16;
   localparam int RANDOM_ITEMS = 1150;
   localparam vmt_pkg::word_type UNIT_Q = vmt_pkg::word_type'(1) << FRAC;
   localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
   localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

   // one request as the driver sees it, with an optional hand-written answer
   typedef struct packed {
      logic                 op;
      logic [3:0]           idx;
      vmt_pkg::word_type    val;
      vmt_pkg::word_type    vx;
      vmt_pkg::word_type    vy;
      vmt_pkg::word_type    vz;
      vmt_pkg::word_type    vw;
      logic                 known;
      vmt_pkg::result_type  res;
   } vertex_req_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_op;
   logic [3:0]         req_element_index;
   logic signed [31:0] req_element_value;
   logic signed [31:0] req_vx;
   logic signed [31:0] req_vy;
   logic signed [31:0] req_vz;
   logic signed [31:0] req_vw;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic signed [31:0] rsp_out_w;
   logic               rsp_clipped;

   // answer carried along with the request currently on the bus
   logic                row_known;
   vmt_pkg::result_type row_result;

   vmt_pkg::word_type    matrix_mirror [16];
   vmt_pkg::result_type  xform_expect_q [$];
   vertex_req_type       directed_q [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;
   int load_count = 0;
   int xform_count = 0;
   int rsp_count = 0;
   int clip_count = 0;

   vertex_matrix_transform #(
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_element_index(req_element_index),
      .req_element_value(req_element_value),
      .req_vx(req_vx),
      .req_vy(req_vy),
      .req_vz(req_vz),
      .req_vw(req_vw),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_out_w(rsp_out_w),
      .rsp_clipped(rsp_clipped)
   );

   always #5 clock = ~clock;

   // matrix times vertex: exact 66-bit sum, floor shift, saturate
   function automatic vmt_pkg::result_type predict_xform(input vmt_pkg::word_type vx,
                                                         input vmt_pkg::word_type vy,
                                                         input vmt_pkg::word_type vz,
                                                         input vmt_pkg::word_type vw);
      logic signed [65:0]  acc;
      logic signed [65:0]  shifted;
      vmt_pkg::word_type   vec [4];
      vmt_pkg::word_type   comp [4];
      vmt_pkg::result_type r;
      vec[0] = vx;
      vec[1] = vy;
      vec[2] = vz;
      vec[3] = vw;
      r.clipped = 1'b0;
      for (int row = 0; row < 4; row++) begin
         acc = '0;
         for (int col = 0; col < 4; col++)
            acc = acc + $signed(matrix_mirror[col*4 + row]) * $signed(vec[col]);
         shifted = acc >>> FRAC;
         if (shifted > WIDE_MAX) begin
            comp[row] = vmt_pkg::SAT_MAX;
            r.clipped = 1'b1;
         end else if (shifted < WIDE_MIN) begin
            comp[row] = vmt_pkg::SAT_MIN;
            r.clipped = 1'b1;
         end else begin
            comp[row] = shifted[31:0];
         end
      end
      r.out_x = comp[0];
      r.out_y = comp[1];
      r.out_z = comp[2];
      r.out_w = comp[3];
      return r;
   endfunction

   // random Q16.16 word: full range, small magnitudes, unit values or limits
   function automatic vmt_pkg::word_type pick_q16(input int wide_pct);
      vmt_pkg::word_type w;
      w = $urandom;
      if ($urandom_range(99) < wide_pct)
         return w;
      case ($urandom_range(9))
         7: begin
            case ($urandom_range(3))
               0: return UNIT_Q;
               1: return -UNIT_Q;
               2: return '0;
               default: return vmt_pkg::word_type'(1);
            endcase
         end
         8: return vmt_pkg::SAT_MAX;
         9: return vmt_pkg::SAT_MIN;
         default: return {{12{w[19]}}, w[19:0]};
      endcase
   endfunction

   // directed table rows
   task automatic add_load(input logic [3:0] idx, input vmt_pkg::word_type val);
      vertex_req_type rq;
      rq.op = vmt_pkg::OP_LOAD;
      rq.idx = idx;
      rq.val = val;
      rq.vx = $urandom;
      rq.vy = $urandom;
      rq.vz = $urandom;
      rq.vw = $urandom;
      rq.known = 1'b0;
      rq.res = '0;
      directed_q.push_back(rq);
   endtask

   task automatic add_xform(input vmt_pkg::word_type vx, input vmt_pkg::word_type vy,
                            input vmt_pkg::word_type vz, input vmt_pkg::word_type vw,
                            input logic known, input vmt_pkg::word_type ex,
                            input vmt_pkg::word_type ey, input vmt_pkg::word_type ez,
                            input vmt_pkg::word_type ew, input logic ec);
      vertex_req_type rq;
      rq.op = vmt_pkg::OP_XFORM;
      rq.idx = 4'($urandom);
      rq.val = $urandom;
      rq.vx = vx;
      rq.vy = vy;
      rq.vz = vz;
      rq.vw = vw;
      rq.known = known;
      rq.res.out_x = ex;
      rq.res.out_y = ey;
      rq.res.out_z = ez;
      rq.res.out_w = ew;
      rq.res.clipped = ec;
      directed_q.push_back(rq);
   endtask

   // present one request, with random idle cycles ahead of it
   task automatic drive_request(input vertex_req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= rq.op;
      req_element_index <= rq.idx;
      req_element_value <= rq.val;
      req_vx <= rq.vx;
      req_vy <= rq.vy;
      req_vz <= rq.vz;
      req_vw <= rq.vw;
      row_known <= rq.known;
      row_result <= rq.res;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // response back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // track accepted requests and check responses in order
   always @(posedge clock) begin
      vmt_pkg::result_type got;
      vmt_pkg::result_type want;
      logic [4:0] diff;
      if (reset) begin
         for (int i = 0; i < 16; i++)
            matrix_mirror[i] = (i % 5 == 0) ? UNIT_Q : '0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_op == vmt_pkg::OP_LOAD) begin
               matrix_mirror[req_element_index] = req_element_value;
               load_count++;
            end else begin
               xform_expect_q.push_back(row_known ? row_result :
                  predict_xform(req_vx, req_vy, req_vz, req_vw));
               xform_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.out_x = rsp_out_x;
            got.out_y = rsp_out_y;
            got.out_z = rsp_out_z;
            got.out_w = rsp_out_w;
            got.clipped = rsp_clipped;
            rsp_count++;
            if (rsp_clipped === 1'b1)
               clip_count++;
            if (xform_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response x=%h y=%h z=%h w=%h clipped=%b",
                           got.out_x, got.out_y, got.out_z, got.out_w, got.clipped);
            end else begin
               want = xform_expect_q.pop_front();
               diff = {want.out_x !== got.out_x, want.out_y !== got.out_y,
                       want.out_z !== got.out_z, want.out_w !== got.out_w,
                       want.clipped !== got.clipped};
               if (diff != '0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("response %0d mismatch (fields x y z w clipped = %b)",
                              rsp_count, diff);
                     $display("  expected x=%h y=%h z=%h w=%h clipped=%b",
                              want.out_x, want.out_y, want.out_z, want.out_w, want.clipped);
                     $display("  actual   x=%h y=%h z=%h w=%h clipped=%b",
                              got.out_x, got.out_y, got.out_z, got.out_w, got.clipped);
                  end
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      vertex_req_type rq;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = vmt_pkg::OP_LOAD;
      req_element_index = '0;
      req_element_value = '0;
      req_vx = '0;
      req_vy = '0;
      req_vz = '0;
      req_vw = '0;
      row_known = 1'b0;
      row_result = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset passes vertices through unchanged
      add_xform(UNIT_Q, 32'hFFFE_0000, vmt_pkg::SAT_MAX, vmt_pkg::SAT_MIN, 1'b1,
                UNIT_Q, 32'hFFFE_0000, vmt_pkg::SAT_MAX, vmt_pkg::SAT_MIN, 1'b0);
      add_xform('0, '0, '0, '0, 1'b1, '0, '0, '0, '0, 1'b0);
      add_xform('1, '1, '1, '1, 1'b1, '1, '1, '1, '1, 1'b0);
      // positive and negative saturation on one component
      add_load(4'd0, vmt_pkg::SAT_MAX);
      add_xform(vmt_pkg::SAT_MAX, '0, '0, '0, 1'b1, vmt_pkg::SAT_MAX, '0, '0, '0, 1'b1);
      add_load(4'd0, vmt_pkg::SAT_MIN);
      add_xform(vmt_pkg::SAT_MAX, '0, '0, '0, 1'b1, vmt_pkg::SAT_MIN, '0, '0, '0, 1'b1);
      add_xform(vmt_pkg::SAT_MIN, '0, '0, '0, 1'b1, vmt_pkg::SAT_MAX, '0, '0, '0, 1'b1);
      // tiny negative product rounds toward minus infinity
      add_load(4'd0, vmt_pkg::word_type'(1));
      add_xform('1, '0, '0, '0, 1'b1, '1, '0, '0, '0, 1'b0);
      add_load(4'd0, UNIT_Q);
      // large products that cancel within a row
      add_load(4'd4, vmt_pkg::SAT_MAX);
      add_load(4'd8, vmt_pkg::SAT_MIN);
      add_xform('0, vmt_pkg::SAT_MAX, vmt_pkg::SAT_MAX, '0, 1'b0, '0, '0, '0, '0, 1'b0);
      add_load(4'd15, 32'hFFFF_8000);
      add_load(4'd3, 32'h0002_0000);
      add_xform(32'h0003_4000, 32'hFFFF_C000, 32'h0000_0001, 32'h0001_8000,
                1'b0, '0, '0, '0, '0, 1'b0);
      // rows 0 to 2 of column 3 at a limit
      add_load(4'd12, vmt_pkg::SAT_MAX);
      add_load(4'd13, vmt_pkg::SAT_MAX);
      add_load(4'd14, vmt_pkg::SAT_MIN);
      add_xform(vmt_pkg::SAT_MAX, vmt_pkg::SAT_MAX, vmt_pkg::SAT_MAX, vmt_pkg::SAT_MAX,
                1'b0, '0, '0, '0, '0, 1'b0);
      add_xform(vmt_pkg::SAT_MIN, vmt_pkg::SAT_MIN, vmt_pkg::SAT_MIN, vmt_pkg::SAT_MIN,
                1'b0, '0, '0, '0, '0, 1'b0);

      send_idle_pct = 28;
      rsp_stall_pct = 49;
      foreach (directed_q[i])
         drive_request(directed_q[i]);

      // random mix of loads and transforms over three idling phases
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 49;
            rsp_stall_pct = 28;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         rq.op = ($urandom_range(99) < 35) ? vmt_pkg::OP_LOAD : vmt_pkg::OP_XFORM;
         rq.idx = 4'($urandom);
         rq.val = pick_q16((rq.op == vmt_pkg::OP_LOAD) ? 10 : 40);
         rq.vx = pick_q16(30);
         rq.vy = pick_q16(30);
         rq.vz = pick_q16(30);
         rq.vw = pick_q16(30);
         rq.known = 1'b0;
         rq.res = '0;
         drive_request(rq);
      end
      req_valid <= 1'b0;

      // drain, then watch for stray responses
      while (xform_expect_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("run covered %0d matrix loads and %0d transforms", load_count, xform_count);
      $display("%0d responses checked, %0d of them saturated, %0d mismatches",
               rsp_count, clip_count, mismatch_count);
      if (mismatch_count == 0 && xform_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("timeout with %0d responses outstanding", xform_expect_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule

### files.f
hw/rtl/vmt_pkg.sv
hw/rtl/vmt_lane.sv
hw/rtl/vmt_merge.sv
hw/rtl/vertex_matrix_transform.sv
verif/testbench.sv
